/* hdl/mcmq_pkg.sv */
// ----------------------------------------------------------------------------
// Message queue package
// Sequencer states and result status codes of the message queue unit.
// ----------------------------------------------------------------------------
package mcmq_pkg;

   // one-hot sequencer states
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_COPY  = 4'b0100,
      ST_OUT   = 4'b1000
   } mcmq_state_type;

   // result status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_INVALID = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;
   localparam logic [1:0] STAT_PERSIST = 2'd3;

   localparam logic OP_SEND = 1'b0;
   localparam logic OP_RECV = 1'b1;

endpackage

/* hdl/multi_channel_message_queue_unit.sv */
// ----------------------------------------------------------------------------
// Multi-channel message queue unit
// Mailbox of CHANNELS rings, QUEUE_DEPTH messages each, held in RAMs.
// ----------------------------------------------------------------------------
// Usage: a send payload word that is not the last of its message is staged
// and busy stays low. The last word of a send, or a receive, reads the
// channel's state RAM and decides; a committed send then copies the staged
// payload into the payload RAM one word a cycle, WORDS = ceil(PAYLOAD_BYTES/8)
// words in all, with busy high. A receive streams WORDS results, one each
// cycle, taken from the payload RAM read port, with busy high. An invalid
// channel gives its one result the cycle after the item without raising busy;
// a drop, a failed persistence or an empty receive gives it after the check
// state, in which busy is high for the state read. Results are strobed for
// one cycle and cannot be held off; the receiver must take every strobed
// cycle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module multi_channel_message_queue_unit #(
   parameter int CHANNELS      = 64,
   parameter int QUEUE_DEPTH   = 16,
   parameter int PAYLOAD_BYTES = 240
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [5:0]  req_channel,
   input  logic [31:0] req_sender_id,
   input  logic [31:0] req_message_type,
   input  logic [7:0]  req_payload_length,
   input  logic [63:0] req_payload_word,
   input  logic        req_word_last,
   input  logic        req_persist_ok,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_sequence_number,
   output logic [31:0] rsp_sender_id_out,
   output logic [31:0] rsp_message_type_out,
   output logic [7:0]  rsp_payload_length_out,
   output logic [63:0] rsp_payload_word_out,
   output logic        rsp_last_result,
   output logic [4:0]  rsp_queued_count,
   output logic [63:0] rsp_dropped_total,
   input  logic        csr_write_enable,
   input  logic [6:0]  csr_write_data
);

   import mcmq_pkg::*;

   localparam int WORDS  = (PAYLOAD_BYTES + 7) / 8;
   localparam int CW     = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
   localparam int PW     = $clog2(QUEUE_DEPTH);
   localparam int FW     = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOTS  = CHANNELS * QUEUE_DEPTH;
   localparam int SW     = $clog2(SLOTS);
   localparam int PDEPTH = SLOTS * WORDS;
   localparam int PAW    = $clog2(PDEPTH);
   localparam int KW     = WORDS > 1 ? $clog2(WORDS) : 1;
   localparam int WCW    = $clog2(WORDS + 1);
   localparam int LW     = $clog2(PAYLOAD_BYTES + 1);
   localparam int CSW    = 2 * PW + FW + 64;
   localparam int HW     = 64 + LW;

   typedef struct packed {
      logic [PW-1:0] rd_pos;
      logic [PW-1:0] wr_pos;
      logic [FW-1:0] fill;
      logic [63:0]   drops;
   } chan_state_type;

   // registers
   mcmq_state_type state_ff, state_in;
   logic [6:0]     csr_ff;
   logic [WCW-1:0] wpos_ff, wpos_in, cnt_ff, cnt_in;
   logic           op_ff, op_in, pok_ff, pok_in;
   logic [CW-1:0]  ch_ff, ch_in;
   logic [31:0]    snd_ff, snd_in, typ_ff, typ_in;
   logic [LW-1:0]  len_ff, len_in;
   logic [63:0]    seq_ff, seq_in, rseq_ff, rseq_in, drop_ff, drop_in;
   logic [KW-1:0]  k_ff, k_in, cpk_ff, cpk_in, ok_ff, ok_in;
   logic [SW-1:0]  slot_ff, slot_in;
   logic [PAW-1:0] base_ff, base_in;
   logic           cpv_ff, cpv_in, ov_ff, ov_in, sv_ff, sv_in;
   logic [1:0]     st_ff, st_in;
   logic [FW-1:0]  q_ff, q_in;
   logic [CHANNELS-1:0] vld_ff, vld_in;

   // RAM ports
   logic           stg_we;
   logic [63:0]    stg_rd;
   logic           ch_we;
   chan_state_type ch_wd, ch_rd, cs;
   logic           hd_we;
   logic [HW-1:0]  hd_wd, hd_rd;
   logic           pl_we;
   logic [63:0]    pl_wd, pl_rd;

   logic           acc, chan_ok;
   logic [LW-1:0]  len_clamp;
   logic [SW-1:0]  slot_c;
   logic [63:0]    byte_mask;

   // ---- memories ----
   mcmq_ram #(.WIDTH(64), .DEPTH(WORDS)) u_stage (
      .clock(clock), .wr_en(stg_we), .wr_addr(KW'(wpos_ff)), .wr_data(req_payload_word),
      .rd_addr(k_ff), .rd_data(stg_rd)
   );

   mcmq_ram #(.WIDTH(CSW), .DEPTH(CHANNELS)) u_chan (
      .clock(clock), .wr_en(ch_we), .wr_addr(ch_ff), .wr_data(ch_wd),
      .rd_addr(CW'(req_channel)), .rd_data(ch_rd)
   );

   mcmq_ram #(.WIDTH(HW), .DEPTH(SLOTS)) u_head (
      .clock(clock), .wr_en(hd_we), .wr_addr(slot_c), .wr_data(hd_wd),
      .rd_addr(slot_ff), .rd_data(hd_rd)
   );

   mcmq_ram #(.WIDTH(64), .DEPTH(PDEPTH)) u_payload (
      .clock(clock), .wr_en(pl_we), .wr_addr(base_ff + PAW'(cpk_ff)), .wr_data(pl_wd),
      .rd_addr(base_ff + PAW'(k_ff)), .rd_data(pl_rd)
   );

   // ---- handshake and input decode ----
   assign busy    = (state_ff != ST_IDLE) || cpv_ff || ov_ff;
   assign acc     = start && !busy;
   assign chan_ok = (32'(req_channel) < 32'(CHANNELS)) && (7'(req_channel) < csr_ff);
   assign len_clamp = (32'(req_payload_length) > 32'(PAYLOAD_BYTES)) ?
                      LW'(PAYLOAD_BYTES) : LW'(req_payload_length);
   assign stg_we  = acc && (req_operation == OP_SEND) && (32'(wpos_ff) < 32'(WORDS));

   // a channel never written reads as reset state
   assign cs = vld_ff[ch_ff] ? ch_rd : '0;

   // header slot of the current check
   assign slot_c = SW'(ch_ff) * SW'(QUEUE_DEPTH) +
                   SW'((op_ff == OP_SEND) ? cs.wr_pos : cs.rd_pos);
   assign hd_wd  = {snd_ff, typ_ff, len_ff};

   // mask bytes of the copied word at or past the length
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         byte_mask[b*8 +: 8] = ((32'(cpk_ff) * 32'd8 + 32'(b)) < 32'(len_ff)) ?
                               8'hFF : 8'h00;
      end
   end

   assign pl_we = cpv_ff;
   assign pl_wd = (32'(cpk_ff) < 32'(cnt_ff)) ? (stg_rd & byte_mask) : 64'd0;

   // ---- sequencer ----
   always_comb begin
      state_in = state_ff;
      wpos_in  = wpos_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      ch_in    = ch_ff;
      snd_in   = snd_ff;
      typ_in   = typ_ff;
      len_in   = len_ff;
      pok_in   = pok_ff;
      seq_in   = seq_ff;
      rseq_in  = rseq_ff;
      drop_in  = drop_ff;
      k_in     = k_ff;
      slot_in  = slot_ff;
      base_in  = base_ff;
      cpv_in   = 1'b0;
      cpk_in   = cpk_ff;
      ov_in    = 1'b0;
      ok_in    = ok_ff;
      sv_in    = 1'b0;
      st_in    = st_ff;
      q_in     = q_ff;
      vld_in   = vld_ff;
      ch_we    = 1'b0;
      ch_wd    = cs;
      hd_we    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               op_in  = req_operation;
               ch_in  = CW'(req_channel);
               snd_in = req_sender_id;
               typ_in = req_message_type;
               len_in = len_clamp;
               pok_in = req_persist_ok;
               if (req_operation == OP_SEND) begin
                  // stage the word; decide on the last one
                  if (stg_we) begin
                     wpos_in = wpos_ff + WCW'(1);
                  end
                  if (req_word_last) begin
                     wpos_in = '0;
                     cnt_in  = wpos_ff + WCW'(stg_we);
                     if (chan_ok) begin
                        state_in = ST_CHECK;
                     end else begin
                        sv_in   = 1'b1;
                        st_in   = STAT_INVALID;
                        rseq_in = '0;
                        q_in    = '0;
                        drop_in = '0;
                     end
                  end
               end else if (chan_ok) begin
                  state_in = ST_CHECK;
               end else begin
                  sv_in   = 1'b1;
                  st_in   = STAT_INVALID;
                  rseq_in = '0;
                  q_in    = '0;
                  drop_in = '0;
               end
            end
         end

         ST_CHECK: begin
            state_in = ST_IDLE;
            k_in     = '0;
            slot_in  = slot_c;
            base_in  = PAW'(slot_c) * PAW'(WORDS);
            rseq_in  = '0;
            q_in     = cs.fill;
            drop_in  = cs.drops;
            if (op_ff == OP_SEND) begin
               sv_in = 1'b1;
               if (32'(cs.fill) >= 32'(QUEUE_DEPTH)) begin
                  // ring full: count a drop
                  st_in       = STAT_FULL;
                  drop_in     = cs.drops + 64'd1;
                  ch_wd.drops = cs.drops + 64'd1;
                  ch_we       = 1'b1;
                  vld_in[ch_ff] = 1'b1;
               end else begin
                  seq_in  = seq_ff + 64'd1;
                  rseq_in = seq_ff + 64'd1;
                  if (!pok_ff) begin
                     st_in = STAT_PERSIST;
                  end else begin
                     // commit header and state, then copy payload
                     st_in        = STAT_OK;
                     q_in         = cs.fill + FW'(1);
                     ch_wd.fill   = cs.fill + FW'(1);
                     ch_wd.wr_pos = (cs.wr_pos == PW'(QUEUE_DEPTH - 1)) ?
                                    '0 : cs.wr_pos + PW'(1);
                     ch_we        = 1'b1;
                     vld_in[ch_ff] = 1'b1;
                     hd_we        = 1'b1;
                     state_in     = ST_COPY;
                  end
               end
            end else if (cs.fill == '0) begin
               sv_in = 1'b1;
               st_in = STAT_FULL;
            end else begin
               // pop the oldest message and stream it
               q_in         = cs.fill - FW'(1);
               ch_wd.fill   = cs.fill - FW'(1);
               ch_wd.rd_pos = (cs.rd_pos == PW'(QUEUE_DEPTH - 1)) ?
                              '0 : cs.rd_pos + PW'(1);
               ch_we        = 1'b1;
               vld_in[ch_ff] = 1'b1;
               state_in     = ST_OUT;
            end
         end

         ST_COPY: begin
            cpv_in = 1'b1;
            cpk_in = k_ff;
            if (32'(k_ff) == 32'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end

         ST_OUT: begin
            ov_in = 1'b1;
            ok_in = k_ff;
            if (32'(k_ff) == 32'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         csr_ff   <= '0;
         wpos_ff  <= '0;
         seq_ff   <= '0;
         cpv_ff   <= 1'b0;
         ov_ff    <= 1'b0;
         sv_ff    <= 1'b0;
         vld_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            csr_ff <= csr_write_data;
         end
         wpos_ff  <= wpos_in;
         seq_ff   <= seq_in;
         cpv_ff   <= cpv_in;
         ov_ff    <= ov_in;
         sv_ff    <= sv_in;
         vld_ff   <= vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      op_ff   <= op_in;
      ch_ff   <= ch_in;
      snd_ff  <= snd_in;
      typ_ff  <= typ_in;
      len_ff  <= len_in;
      pok_ff  <= pok_in;
      rseq_ff <= rseq_in;
      drop_ff <= drop_in;
      k_ff    <= k_in;
      slot_ff <= slot_in;
      base_ff <= base_in;
      cpk_ff  <= cpk_in;
      ok_ff   <= ok_in;
      st_ff   <= st_in;
      q_ff    <= q_in;
   end

   // ---- result port ----
   assign rsp_strobe             = sv_ff || ov_ff;
   assign rsp_status             = ov_ff ? STAT_OK : st_ff;
   assign rsp_sequence_number    = ov_ff ? 64'd0 : rseq_ff;
   assign rsp_sender_id_out      = ov_ff ? hd_rd[HW-1 -: 32] : 32'd0;
   assign rsp_message_type_out   = ov_ff ? hd_rd[HW-33 -: 32] : 32'd0;
   assign rsp_payload_length_out = ov_ff ? 8'(hd_rd[LW-1:0]) : 8'd0;
   assign rsp_payload_word_out   = ov_ff ? pl_rd : 64'd0;
   assign rsp_last_result        = ov_ff ? (32'(ok_ff) == 32'(WORDS - 1)) : 1'b1;
   assign rsp_queued_count       = 5'(q_ff);
   assign rsp_dropped_total      = drop_ff;

endmodule

/* hdl/mcmq_ram.sv */
// ----------------------------------------------------------------------------
// Message queue RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mcmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

/* tb/multi_channel_message_queue_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Message queue unit testbench
// Drives send words and receives through the command port. A predictor of
// its own computes the results, which are checked field by field as they
// stream out, with random sender gaps, over several channel counts.
// ----------------------------------------------------------------------------
module multi_channel_message_queue_unit_tb;
   import mcmq_pkg::*;

   localparam int NCH    = 64;
   localparam int DEPTH  = 16;
   localparam int MAXLEN = 240;
   localparam int NWORDS = 30;

   typedef struct packed {
      logic        operation;
      logic [5:0]  channel;
      logic [31:0] sender_id;
      logic [31:0] message_type;
      logic [7:0]  payload_length;
      logic [63:0] payload_word;
      logic        word_last;
      logic        persist_ok;
   } mq_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] sequence_number;
      logic [31:0] sender_id;
      logic [31:0] message_type;
      logic [7:0]  payload_length;
      logic [63:0] payload_word;
      logic        last_result;
      logic [4:0]  queued_count;
      logic [63:0] dropped_total;
   } mq_result_type;

   // directed row: item, plus an optional typed-in expected single result
   typedef struct packed {
      mq_item_type   item;
      logic          has_known;
      mq_result_type known;
   } mq_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_operation;
   logic [5:0]  req_channel;
   logic [31:0] req_sender_id;
   logic [31:0] req_message_type;
   logic [7:0]  req_payload_length;
   logic [63:0] req_payload_word;
   logic        req_word_last;
   logic        req_persist_ok;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_sequence_number;
   logic [31:0] rsp_sender_id_out;
   logic [31:0] rsp_message_type_out;
   logic [7:0]  rsp_payload_length_out;
   logic [63:0] rsp_payload_word_out;
   logic        rsp_last_result;
   logic [4:0]  rsp_queued_count;
   logic [63:0] rsp_dropped_total;
   logic        csr_write_enable;
   logic [6:0]  csr_write_data;

   multi_channel_message_queue_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_channel(req_channel),
      .req_sender_id(req_sender_id), .req_message_type(req_message_type),
      .req_payload_length(req_payload_length), .req_payload_word(req_payload_word),
      .req_word_last(req_word_last), .req_persist_ok(req_persist_ok),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_sequence_number(rsp_sequence_number),
      .rsp_sender_id_out(rsp_sender_id_out),
      .rsp_message_type_out(rsp_message_type_out),
      .rsp_payload_length_out(rsp_payload_length_out),
      .rsp_payload_word_out(rsp_payload_word_out),
      .rsp_last_result(rsp_last_result), .rsp_queued_count(rsp_queued_count),
      .rsp_dropped_total(rsp_dropped_total),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   // predictor state
   logic [63:0] ring_payload [NCH*DEPTH][NWORDS];
   logic [31:0] ring_sender [NCH*DEPTH];
   logic [31:0] ring_type [NCH*DEPTH];
   logic [7:0]  ring_length [NCH*DEPTH];
   int          rd_pos [NCH];
   int          wr_pos [NCH];
   int          fill [NCH];
   logic [63:0] drops [NCH];
   logic [63:0] seq_count;
   int          stage_pos;
   logic [63:0] stage [NWORDS];
   int          active_ch;

   mq_result_type pending_results [$];
   int            error_count;
   int            gap_pct;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic mq_result_type blank_result(input logic [1:0] st);
      mq_result_type r;
      r = '0;
      r.status = st;
      r.last_result = 1'b1;
      return r;
   endfunction

   // compute expected results of one accepted item and queue them
   task automatic predict_mailbox(input mq_item_type it);
      mq_result_type r;
      int ch, slot, len, nbytes;
      logic [63:0] mask;
      logic valid;
      ch = it.channel;
      valid = ch < active_ch;
      if (it.operation == OP_SEND) begin
         if (stage_pos < NWORDS) begin
            stage[stage_pos] = it.payload_word;
            stage_pos++;
         end
         if (!it.word_last) return;
         stage_pos = 0;
         if (!valid) begin
            pending_results.push_back(blank_result(STAT_INVALID));
         end else if (fill[ch] >= DEPTH) begin
            drops[ch]++;
            r = blank_result(STAT_FULL);
            r.queued_count = 5'(fill[ch]);
            r.dropped_total = drops[ch];
            pending_results.push_back(r);
         end else begin
            len = (it.payload_length > MAXLEN) ? MAXLEN : it.payload_length;
            seq_count++;
            r = blank_result(it.persist_ok ? STAT_OK : STAT_PERSIST);
            r.sequence_number = seq_count;
            if (it.persist_ok) begin
               slot = ch * DEPTH + wr_pos[ch];
               ring_sender[slot] = it.sender_id;
               ring_type[slot] = it.message_type;
               ring_length[slot] = 8'(len);
               for (int k = 0; k < NWORDS; k++) begin
                  nbytes = len - 8 * k;
                  if (nbytes <= 0) mask = '0;
                  else if (nbytes >= 8) mask = '1;
                  else mask = (64'd1 << (8 * nbytes)) - 64'd1;
                  ring_payload[slot][k] = stage[k] & mask;
               end
               wr_pos[ch] = (wr_pos[ch] + 1) % DEPTH;
               fill[ch]++;
            end
            r.queued_count = 5'(fill[ch]);
            r.dropped_total = drops[ch];
            pending_results.push_back(r);
         end
         for (int k = 0; k < NWORDS; k++) stage[k] = '0;
      end else begin
         if (!valid) begin
            pending_results.push_back(blank_result(STAT_INVALID));
         end else if (fill[ch] == 0) begin
            r = blank_result(STAT_FULL);
            r.dropped_total = drops[ch];
            pending_results.push_back(r);
         end else begin
            slot = ch * DEPTH + rd_pos[ch];
            rd_pos[ch] = (rd_pos[ch] + 1) % DEPTH;
            fill[ch]--;
            for (int k = 0; k < NWORDS; k++) begin
               r = '0;
               r.status = STAT_OK;
               r.sender_id = ring_sender[slot];
               r.message_type = ring_type[slot];
               r.payload_length = ring_length[slot];
               r.payload_word = ring_payload[slot][k];
               r.last_result = (k == NWORDS - 1);
               r.queued_count = 5'(fill[ch]);
               r.dropped_total = drops[ch];
               pending_results.push_back(r);
            end
         end
      end
   endtask

   // check each strobed result against the oldest expectation
   always @(posedge clock) begin
      mq_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result, status %0d", $realtime, rsp_status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
            if (rsp_sequence_number !== want.sequence_number)
               report_mismatch("sequence", rsp_sequence_number, want.sequence_number);
            if (rsp_sender_id_out !== want.sender_id)
               report_mismatch("sender", 64'(rsp_sender_id_out), 64'(want.sender_id));
            if (rsp_message_type_out !== want.message_type)
               report_mismatch("type", 64'(rsp_message_type_out), 64'(want.message_type));
            if (rsp_payload_length_out !== want.payload_length)
               report_mismatch("length", 64'(rsp_payload_length_out),
                               64'(want.payload_length));
            if (rsp_payload_word_out !== want.payload_word)
               report_mismatch("word", rsp_payload_word_out, want.payload_word);
            if (rsp_last_result !== want.last_result)
               report_mismatch("last", 64'(rsp_last_result), 64'(want.last_result));
            if (rsp_queued_count !== want.queued_count)
               report_mismatch("queued", 64'(rsp_queued_count), 64'(want.queued_count));
            if (rsp_dropped_total !== want.dropped_total)
               report_mismatch("dropped", rsp_dropped_total, want.dropped_total);
         end
      end
   end

   // offer one item from the falling edge until it is taken; start stays
   // high afterwards so that the next item can follow without a gap
   task automatic send_item(input mq_item_type it);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      {req_operation, req_channel, req_sender_id, req_message_type,
       req_payload_length, req_payload_word, req_word_last, req_persist_ok} <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_mailbox(it);
      @(negedge clock);
   endtask

   // drop start and wait until every expected result has come
   task automatic drain_results();
      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // wait out all results, then write the channel count
   task automatic set_channels(input int value);
      drain_results();
      repeat (40) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= 7'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      active_ch = (value > NCH) ? NCH : value;
   endtask

   function automatic mq_item_type make_item(input logic op, input int ch, input logic lst,
                                             input logic pok, input int len);
      mq_item_type it;
      it.operation = op;
      it.channel = 6'(ch);
      it.sender_id = $urandom;
      it.message_type = $urandom;
      it.payload_length = 8'(len);
      it.payload_word = {$urandom, $urandom};
      it.word_last = lst;
      it.persist_ok = pok;
      return it;
   endfunction

   // send a whole message of nw words on a channel
   task automatic send_message(input int ch, input int nw, input logic pok, input int len);
      for (int w = 0; w < nw; w++)
         send_item(make_item(OP_SEND, ch, w == nw - 1, pok, len));
   endtask

   initial begin
      mq_row_type rows [$];
      mq_row_type row;
      int ch, cfg_val;
      error_count = 0;
      gap_pct = 0;
      seq_count = '0;
      stage_pos = 0;
      active_ch = 0;
      for (int c = 0; c < NCH; c++) begin
         rd_pos[c] = 0; wr_pos[c] = 0; fill[c] = 0; drops[c] = '0;
      end
      for (int k = 0; k < NWORDS; k++) stage[k] = '0;
      reset = 1'b1;
      start = 1'b0;
      {req_operation, req_channel, req_sender_id, req_message_type,
       req_payload_length, req_payload_word, req_word_last, req_persist_ok} = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // after reset no channel exists: both operations are rejected
      row = '0;
      row.item = make_item(OP_RECV, 0, 1'b1, 1'b1, 8);
      row.has_known = 1'b1;
      row.known = blank_result(STAT_INVALID);
      rows.push_back(row);
      row.item = make_item(OP_SEND, 63, 1'b1, 1'b1, 255);
      rows.push_back(row);
      foreach (rows[i]) begin
         send_item(rows[i].item);
         if (rows[i].has_known && pending_results[pending_results.size()-1] !== rows[i].known)
            report_mismatch("directed row", 64'(i), 64'd0);
      end
      rows.delete();

      // full range of channels; extremes of fields
      set_channels(127);
      row = '0;
      row.item = make_item(OP_RECV, 63, 1'b0, 1'b0, 0);
      row.has_known = 1'b1;
      row.known = blank_result(STAT_FULL);
      rows.push_back(row);
      row.has_known = 1'b0;
      row.item = make_item(OP_SEND, 63, 1'b1, 1'b1, 255);
      row.item.payload_word = '1; row.item.sender_id = '1; row.item.message_type = '1;
      rows.push_back(row);
      row.item = make_item(OP_RECV, 63, 1'b0, 1'b0, 0);
      rows.push_back(row);
      row.item = make_item(OP_SEND, 0, 1'b0, 1'b0, 0);
      row.item.payload_word = '1;
      rows.push_back(row);
      row.item = make_item(OP_RECV, 5, 1'b0, 1'b0, 0);
      rows.push_back(row);
      row.item = make_item(OP_SEND, 0, 1'b1, 1'b1, 13);
      row.item.payload_word = '1;
      rows.push_back(row);
      row.item = make_item(OP_SEND, 1, 1'b1, 1'b0, 0);
      rows.push_back(row);
      row.item = make_item(OP_RECV, 0, 1'b0, 1'b0, 0);
      row.item.sender_id = '0; row.item.message_type = '0; row.item.payload_word = '0;
      rows.push_back(row);
      foreach (rows[i]) begin
         send_item(rows[i].item);
         if (rows[i].has_known && pending_results[pending_results.size()-1] !== rows[i].known)
            report_mismatch("directed row", 64'(i), 64'd0);
      end
      // long send past the payload words, then fill a ring and overflow it
      send_message(2, 33, 1'b1, 240);
      for (int m = 0; m < DEPTH + 2; m++) send_message(3, 1, 1'b1, 8);
      send_item(make_item(OP_RECV, 2, 1'b0, 1'b0, 0));

      // random phases over channel counts and sender gaps
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: cfg_val = 1;
            1: cfg_val = 64;
            2: cfg_val = $urandom_range(2, 63);
            default: cfg_val = 0;
         endcase
         gap_pct = (phase == 1 || phase == 3) ? 62 : (phase == 2 ? 11 : 0);
         set_channels(cfg_val);
         for (int n = 0; n < 4; n++) begin
            ch = (cfg_val == 0) ? $urandom_range(63)
               : ($urandom_range(9) == 0 ? $urandom_range(63) : $urandom_range(cfg_val - 1));
            if ($urandom_range(2) == 0) begin
               send_item(make_item(OP_RECV, ch, 1'($urandom), 1'($urandom), $urandom));
            end else begin
               send_message(ch, $urandom_range(7) == 0 ? $urandom_range(1, 32)
                            : $urandom_range(1, 3),
                            $urandom_range(4) != 0, $urandom_range(255));
            end
         end
         // let every result come in before moving on
         drain_results();
      end

      drain_results();
      repeat (40) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
